@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on clk, off while rst_n is low
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check on clk, also live during reset
`define ASSERT_CLK_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/ldwt_pkg.sv @@
package ldwt_pkg;

  localparam int SAMPLE_BITS_DEF = 18;
  localparam int MAX_RES         = 3;
  localparam int CNT_W           = $clog2(MAX_RES + 1);
  localparam int PTR_W           = $clog2(MAX_RES);

  localparam logic DIR_FWD = 1'b0;
  localparam logic DIR_INV = 1'b1;

  typedef struct packed {
    logic [CNT_W-1:0]   count;
    logic [MAX_RES-1:0] high;
    logic [MAX_RES-1:0] last;
  } res_ctl_t;

endpackage

@@ rtl/ldwt_lift.sv @@
module ldwt_lift #(
  parameter int SAMPLE_BITS = ldwt_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          line_end,
  input  logic                          direction,
  output logic signed [SAMPLE_BITS:0]   res_val [ldwt_pkg::MAX_RES],
  output ldwt_pkg::res_ctl_t            res_ctl
);

  localparam int W = SAMPLE_BITS + 4;
  localparam logic signed [W-1:0] SAT_HI = W'((64'sd1 <<< SAMPLE_BITS) - 64'sd1);
  localparam logic signed [W-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [W-1:0] TWO    = W'(2);

  function automatic logic signed [SAMPLE_BITS:0] sat(input logic signed [W-1:0] v);
    logic signed [W-1:0] c;
    begin
      if (v > SAT_HI) begin
        c = SAT_HI;
      end else if (v < SAT_LO) begin
        c = SAT_LO;
      end else begin
        c = v;
      end
      return $signed(c[SAMPLE_BITS:0]);
    end
  endfunction

  logic signed [SAMPLE_BITS-1:0] wa_r, wb_r;
  logic signed [SAMPLE_BITS:0]   prior_r, prior_nxt;
  logic [1:0]                    cnt_r, cnt_nxt;
  logic                          par_r, par_nxt;

  logic signed [W-1:0] w0, w1, w2, pr;
  logic signed [W-1:0] d_mid, dp, lo_mid, d_end, lo_end1, lo_endp0, lo_endp1;
  logic signed [W-1:0] left, e_odd, rec_odd, e_end, rec_end, w2e;
  logic signed [W-1:0] v [ldwt_pkg::MAX_RES];

  assign w0 = W'(wa_r);
  assign w1 = W'(wb_r);
  assign w2 = W'(sample);
  assign pr = W'(prior_r);

  assign d_mid    = w1 - ((w0 + w2) >>> 1);
  assign dp       = (cnt_r == 2'd2) ? d_mid : pr;
  assign lo_mid   = w0 + ((dp + d_mid + TWO) >>> 2);
  assign d_end    = w2 - w1;
  assign lo_end1  = w1 + (((d_end <<< 1) + TWO) >>> 2);
  assign lo_endp0 = w2 + (((d_mid <<< 1) + TWO) >>> 2);
  assign lo_endp1 = w1 + ((pr + d_end + TWO) >>> 2);

  assign left     = (cnt_r == 2'd1) ? w2 : w0;
  assign e_odd    = w1 - ((left + w2 + TWO) >>> 2);
  assign rec_odd  = w0 + ((pr + e_odd) >>> 1);
  assign e_end    = w2 - (((w1 <<< 1) + TWO) >>> 2);
  assign rec_end  = w1 + ((pr + e_end) >>> 1);
  assign w2e      = w2 + e_odd;

  always_comb begin
    for (int i = 0; i < ldwt_pkg::MAX_RES; i++) begin
      v[i] = '0;
    end
    res_ctl   = '0;
    prior_nxt = prior_r;
    cnt_nxt   = cnt_r;
    par_nxt   = par_r;
    if (!line_end) begin
      if (direction == ldwt_pkg::DIR_FWD) begin
        if (cnt_r[1]) begin
          res_ctl.count = ldwt_pkg::CNT_W'(1);
          if (!par_r) begin
            v[0]      = lo_mid;
            prior_nxt = sat(d_mid);
          end else begin
            v[0]           = pr;
            res_ctl.high[0] = 1'b1;
          end
        end
      end else begin
        if (par_r) begin
          if (cnt_r == 2'd3) begin
            v[0]            = rec_odd;
            res_ctl.high[0] = 1'b1;
            res_ctl.count   = ldwt_pkg::CNT_W'(1);
          end
          prior_nxt = sat(e_odd);
        end else if (cnt_r[1]) begin
          v[0]          = pr;
          res_ctl.count = ldwt_pkg::CNT_W'(1);
        end
      end
      cnt_nxt = (cnt_r == 2'd3) ? 2'd3 : cnt_r + 2'd1;
      par_nxt = ~par_r;
    end else begin
      cnt_nxt = 2'd0;
      par_nxt = 1'b0;
      if (cnt_r == 2'd0) begin
        v[0]            = w2;
        res_ctl.count   = ldwt_pkg::CNT_W'(1);
        res_ctl.last[0] = 1'b1;
      end else if (cnt_r == 2'd1) begin
        res_ctl.count   = ldwt_pkg::CNT_W'(2);
        res_ctl.high[1] = 1'b1;
        res_ctl.last[1] = 1'b1;
        if (direction == ldwt_pkg::DIR_FWD) begin
          v[0] = lo_end1;
          v[1] = d_end;
        end else begin
          v[0] = e_odd;
          v[1] = w2e;
        end
      end else if (!par_r) begin
        res_ctl.count   = ldwt_pkg::CNT_W'(3);
        res_ctl.high[1] = 1'b1;
        res_ctl.last[2] = 1'b1;
        if (direction == ldwt_pkg::DIR_FWD) begin
          v[0] = lo_mid;
          v[1] = d_mid;
          v[2] = lo_endp0;
        end else begin
          v[0] = pr;
          v[1] = rec_end;
          v[2] = e_end;
        end
      end else begin
        res_ctl.count   = ldwt_pkg::CNT_W'(3);
        res_ctl.high[0] = 1'b1;
        res_ctl.high[2] = 1'b1;
        res_ctl.last[2] = 1'b1;
        if (direction == ldwt_pkg::DIR_FWD) begin
          v[0] = pr;
          v[1] = lo_endp1;
          v[2] = d_end;
        end else begin
          v[0] = rec_odd;
          v[1] = e_odd;
          v[2] = w2e;
        end
      end
    end
    for (int i = 0; i < ldwt_pkg::MAX_RES; i++) begin
      res_val[i] = sat(v[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wa_r    <= '0;
      wb_r    <= '0;
      prior_r <= '0;
      cnt_r   <= 2'd0;
      par_r   <= 1'b0;
    end else if (accept) begin
      wa_r    <= wb_r;
      wb_r    <= sample;
      prior_r <= prior_nxt;
      cnt_r   <= cnt_nxt;
      par_r   <= par_nxt;
    end
  end

endmodule

@@ rtl/lifting_dwt53_1d.sv @@
// Reversible 5/3 lifting wavelet, one dimension, streamed in interleaved order.
// Input channel (in_*): one sample or coefficient per beat, in_tlast on the
// final element of a line. Result channel (out_*): one value per beat in
// position order; out_tuser is 1 on odd (high-pass) positions, out_tlast on
// the final result of the line. cfg_wr_en/cfg_wr_data set the direction
// (0 forward, 1 inverse); write it only while the block is idle.
// Results trail the inputs by two positions; the line-end beat flushes up to
// three results. An accepted beat's results go through the result buffer and
// then the result register to out_*. Throughput is one input beat per cycle
// while the receiver keeps up; a line-end beat that yields two or three
// results holds in_tready low while the buffer drains them one per cycle.
// When the receiver stalls, the result register holds its beat, the result
// buffer fills, and in_tready drops until space frees up.
// Reset (rst_n low, synchronous) starts a new line, clears the lifting state,
// empties both stages and sets the direction to forward.
module lifting_dwt53_1d #(
  parameter int SAMPLE_BITS = ldwt_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] in_tdata,   // sample_in
  input  logic                                   in_tlast,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [((SAMPLE_BITS + 8) / 8) * 8-1:0] out_tdata,  // value_out
  output logic                                   out_tuser,  // is_high
  output logic                                   out_tlast,
  input  logic                                   cfg_wr_en,
  input  logic                                   cfg_wr_data
);

  localparam int OUT_TDATA_W = ((SAMPLE_BITS + 8) / 8) * 8;

  logic                          dir_r;
  logic                          accept, out_free, move;
  logic signed [SAMPLE_BITS:0]   res_val [ldwt_pkg::MAX_RES];
  ldwt_pkg::res_ctl_t            res_ctl;

  logic signed [SAMPLE_BITS:0]   bval_r [ldwt_pkg::MAX_RES];
  ldwt_pkg::res_ctl_t            bctl_r;
  logic [ldwt_pkg::PTR_W-1:0]    bptr_r;
  logic [ldwt_pkg::CNT_W-1:0]    brem_r;

  logic signed [SAMPLE_BITS:0]   oval_r;
  logic                          ohigh_r, olast_r, ovalid_r;

  assign out_free  = !ovalid_r || out_tready;
  assign move      = (brem_r != '0) && out_free;
  assign in_tready = (brem_r == '0) ||
                     ((brem_r == ldwt_pkg::CNT_W'(1)) && out_free);
  assign accept    = in_tvalid && in_tready;

  ldwt_lift #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_lift (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .sample    ($signed(in_tdata[SAMPLE_BITS-1:0])),
    .line_end  (in_tlast),
    .direction (dir_r),
    .res_val   (res_val),
    .res_ctl   (res_ctl)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= ldwt_pkg::DIR_FWD;
    end else if (cfg_wr_en) begin
      dir_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brem_r <= '0;
      bptr_r <= '0;
    end else if (accept) begin
      brem_r <= res_ctl.count;
      bptr_r <= '0;
    end else if (move) begin
      brem_r <= brem_r - ldwt_pkg::CNT_W'(1);
      bptr_r <= bptr_r + ldwt_pkg::PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bval_r <= res_val;
      bctl_r <= res_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (move) begin
      ovalid_r <= 1'b1;
    end else if (out_tready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      oval_r  <= bval_r[bptr_r];
      ohigh_r <= bctl_r.high[bptr_r];
      olast_r <= bctl_r.last[bptr_r];
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = OUT_TDATA_W'($unsigned(oval_r));
  assign out_tuser  = ohigh_r;
  assign out_tlast  = olast_r;

endmodule

@@ rtl/ldwt_checker.sv @@
`include "assert_macros.svh"

module ldwt_checker #(
  parameter int SAMPLE_BITS = ldwt_pkg::SAMPLE_BITS_DEF
) (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   out_tvalid,
  input logic                                   out_tready,
  input logic [((SAMPLE_BITS + 8) / 8) * 8-1:0] out_tdata,
  input logic                                   out_tuser,
  input logic                                   out_tlast
);

  localparam int OUT_W = ((SAMPLE_BITS + 8) / 8) * 8;

  logic             prev_high_r, prev_last_r;
  logic             out_beat, out_stall, line_head, mid_line;
  logic [OUT_W+1:0] out_bus;

  assign out_beat  = out_tvalid && out_tready;
  assign out_stall = out_tvalid && !out_tready;
  assign line_head = out_tvalid && prev_last_r;
  assign mid_line  = out_tvalid && !prev_last_r;
  assign out_bus   = {out_tlast, out_tuser, out_tdata};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_high_r <= 1'b0;
      prev_last_r <= 1'b1;
    end else if (out_beat) begin
      prev_high_r <= out_tuser;
      prev_last_r <= out_tlast;
    end
  end

  `ASSERT_CLK(a_valid_hold, out_stall |=> out_tvalid, "result beat dropped")
  `ASSERT_CLK(a_data_hold, out_stall |=> $stable(out_bus), "stalled beat changed")
  `ASSERT_CLK(a_line_start_low, line_head |-> !out_tuser, "line must start low")
  `ASSERT_CLK(a_parity_alt, mid_line |-> out_tuser != prev_high_r, "positions out of order")
  `ASSERT_CLK_RST(a_reset_empty, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind lifting_dwt53_1d ldwt_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_ldwt_checker (.*);
